FILE: rtl/tbg_pkg.sv
// Shared types, constants and constant tables for the transform basis generator.
`timescale 1ns / 1ps
package tbg_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int MAX_POINTS = 4096;
  localparam int LEN_W      = 13;
  localparam int K_W        = 16;
  localparam int N_W        = 12;
  localparam int M_W        = 16;
  localparam int DQ_W       = 32;
  localparam int MOD_CELLS  = 32;
  localparam int OCT_CELLS  = 3;
  localparam int Y_BITS     = 30;
  localparam int TAY_CELLS  = 6;
  localparam int T_W        = 31;
  localparam int V_W        = 32;
  localparam int LV_W       = 17;
  localparam int PR_W       = 34;
  localparam int ACC_W      = 35;
  localparam int OUT_W      = 18;

  localparam logic [29:0] Q30_PI4 = 30'd843314857;
  localparam logic [30:0] Q30_ONE = 31'd1 << 30;

  localparam logic [3:0] KIND_DFT  = 4'd0;
  localparam logic [3:0] KIND_IDFT = 4'd1;
  localparam logic [3:0] KIND_DCT1 = 4'd2;
  localparam logic [3:0] KIND_DCT2 = 4'd3;
  localparam logic [3:0] KIND_DCT3 = 4'd4;
  localparam logic [3:0] KIND_DCT4 = 4'd5;
  localparam logic [3:0] KIND_DST1 = 4'd6;
  localparam logic [3:0] KIND_DST2 = 4'd7;
  localparam logic [3:0] KIND_DST3 = 4'd8;
  localparam logic [3:0] KIND_DST4 = 4'd9;
  localparam logic [3:0] KIND_WHT  = 4'd10;
  localparam logic [3:0] KIND_HART = 4'd11;

  localparam logic [1:0] CFG_KIND    = 2'd0;
  localparam logic [1:0] CFG_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_HEIGHT  = 2'd2;
  localparam logic [1:0] CFG_HARTLEY = 2'd3;

  typedef enum logic [2:0] {
    FN_COS,
    FN_SIN,
    FN_DFT,
    FN_IDFT,
    FN_HART
  } fn_t;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic               serr;
    logic               neg;
    logic [2:0]         oct;
    fn_t                fn;
    logic               spec;
    logic signed [15:0] spec_val;
  } side_t;

  typedef struct packed {
    logic [M_W-1:0]  rem;
    logic [M_W-1:0]  m;
    logic [DQ_W-1:0] dq;
  } div_t;

  typedef struct packed {
    logic [T_W-1:0] ts;
    logic [T_W-1:0] tc;
    logic [T_W-1:0] ss;
    logic [T_W-1:0] sc;
    logic [T_W-1:0] x2;
  } tay_t;

  // Taylor divisors for sine (2i)(2i+1) and cosine (2i-1)(2i).
  function automatic logic [7:0] tay_ds(input logic [2:0] i);
    case (i)
      3'd1: tay_ds = 8'd6;
      3'd2: tay_ds = 8'd20;
      3'd3: tay_ds = 8'd42;
      3'd4: tay_ds = 8'd72;
      3'd5: tay_ds = 8'd110;
      3'd6: tay_ds = 8'd156;
      default: tay_ds = 8'd1;
    endcase
  endfunction

  function automatic logic [7:0] tay_dc(input logic [2:0] i);
    case (i)
      3'd1: tay_dc = 8'd2;
      3'd2: tay_dc = 8'd12;
      3'd3: tay_dc = 8'd30;
      3'd4: tay_dc = 8'd56;
      3'd5: tay_dc = 8'd90;
      3'd6: tay_dc = 8'd132;
      default: tay_dc = 8'd1;
    endcase
  endfunction

  // Reciprocals floor(2^32 / d); the quotient estimate is short by at most one.
  function automatic logic [31:0] tay_rs(input logic [2:0] i);
    case (i)
      3'd1: tay_rs = 32'd715827882;
      3'd2: tay_rs = 32'd214748364;
      3'd3: tay_rs = 32'd102261126;
      3'd4: tay_rs = 32'd59652323;
      3'd5: tay_rs = 32'd39045157;
      3'd6: tay_rs = 32'd27531841;
      default: tay_rs = 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] tay_rc(input logic [2:0] i);
    case (i)
      3'd1: tay_rc = 32'd2147483648;
      3'd2: tay_rc = 32'd357913941;
      3'd3: tay_rc = 32'd143165576;
      3'd4: tay_rc = 32'd76695844;
      3'd5: tay_rc = 32'd47721858;
      3'd6: tay_rc = 32'd32537631;
      default: tay_rc = 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

FILE: rtl/transform_basis_generator_unit.sv
// Top level: configuration registers, two basis lanes, complex product and output skid.
`timescale 1ns / 1ps
// Streams separable 2D basis values of the DFT, inverse DFT, DCT-I..IV, DST-I..IV,
// sequency-ordered Walsh-Hadamard or Hartley transform. Each dimension runs in its
// own lane, a row of cells: 32 division-step cells reduce the exact integer phase
// modulo the period, 3 more find the octant, 30 more produce the Q30 angle, and six
// three-stage Taylor cells give sine and cosine. The block takes one word per clock
// while input ready is high. A registered output with a skid stage keeps input ready
// high while one result waits to be taken; input ready drops only while a second
// result sits in the skid stage, and the whole row of cells holds until it moves on.
// Configuration is held in flip-flops and should be written only while no word is
// in flight.
module transform_basis_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  // term_w [15:0], sample_w [27:16], term_h [43:28], sample_h [55:44]
  input  logic [55:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value_re [17:0], value_im [35:18], zero fill [39:36]
  output logic [39:0] out_tdata,
  // size_error [0]
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  // ---------------- configuration ----------------
  logic [3:0]  kind_r;
  logic [12:0] wlen_r, hlen_r;
  logic        hart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= tbg_pkg::KIND_DFT;
      wlen_r <= 13'd8;
      hlen_r <= 13'd8;
      hart_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tbg_pkg::CFG_KIND:    kind_r <= cfg_data[3:0];
        tbg_pkg::CFG_WIDTH:   wlen_r <= cfg_data;
        tbg_pkg::CFG_HEIGHT:  hlen_r <= cfg_data;
        tbg_pkg::CFG_HARTLEY: hart_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  function automatic logic [12:0] eff_len(input logic [12:0] v);
    if (v == '0) return 13'd1;
    if (v > 13'(tbg_pkg::MAX_POINTS)) return 13'(tbg_pkg::MAX_POINTS);
    return v;
  endfunction

  logic [12:0] wlen, hlen;
  logic [3:0]  kind;
  logic        serr, zero;

  always_comb begin
    wlen = eff_len(wlen_r);
    hlen = eff_len(hlen_r);
    kind = hart_r ? tbg_pkg::KIND_HART : kind_r;
    serr = (kind == tbg_pkg::KIND_WHT) &&
           !(((wlen & (wlen - 13'd1)) == '0) && ((hlen & (hlen - 13'd1)) == '0));
    zero = serr || (kind > tbg_pkg::KIND_HART);
  end

  // ---------------- flow control ----------------
  logic en;
  logic out_valid_r, skid_valid_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // ---------------- lanes ----------------
  tbg_pkg::side_t               w_side;
  logic signed [tbg_pkg::LV_W-1:0] w_re, w_im, h_re, h_im;

  tbg_lane u_lane_w (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(in_tvalid), .zero_i(zero), .serr_i(serr), .kind_i(kind),
    .k_i(signed'(in_tdata[15:0])), .n_i(in_tdata[27:16]), .len_i(wlen),
    .side_o(w_side), .re_o(w_re), .im_o(w_im)
  );

  tbg_lane u_lane_h (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(in_tvalid), .zero_i(zero), .serr_i(serr), .kind_i(kind),
    .k_i(signed'(in_tdata[43:28])), .n_i(in_tdata[55:44]), .len_i(hlen),
    .side_o(), .re_o(h_re), .im_o(h_im)
  );

  // ---------------- complex product ----------------
  tbg_pkg::side_t p_side_r, a_side_r;
  logic signed [tbg_pkg::PR_W-1:0]  prr_r, pii_r, pri_r, pir_r;
  logic signed [tbg_pkg::ACC_W-1:0] are_r, aim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_side_r.valid <= 1'b0;
      a_side_r.valid <= 1'b0;
    end else if (en) begin
      p_side_r <= w_side;
      a_side_r <= p_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prr_r <= 34'(w_re) * 34'(h_re);
      pii_r <= 34'(w_im) * 34'(h_im);
      pri_r <= 34'(w_re) * 34'(h_im);
      pir_r <= 34'(w_im) * 34'(h_re);
      are_r <= 35'(prr_r) - 35'(pii_r);
      aim_r <= 35'(pri_r) + 35'(pir_r);
    end
  end

  // Round half away from zero, then saturate to 18 bits.
  function automatic logic [17:0] finish(input logic signed [34:0] acc);
    logic [34:0] mag;
    logic [34:0] rm;
    mag = acc[34] ? 35'(-acc) : 35'(acc);
    rm  = (mag + (35'd1 << (tbg_pkg::FRAC_BITS - 1))) >> tbg_pkg::FRAC_BITS;
    if (acc[34]) begin
      if (rm > 35'd131072) return 18'h20000;
      return 18'(-rm);
    end
    if (rm > 35'd131071) return 18'h1FFFF;
    return rm[17:0];
  endfunction

  logic [17:0] fin_re, fin_im;
  logic        push;

  always_comb begin
    fin_re = a_side_r.zero ? '0 : finish(are_r);
    fin_im = a_side_r.zero ? '0 : finish(aim_r);
    push   = en && a_side_r.valid;
  end

  // ---------------- output register and skid ----------------
  logic [36:0] out_word_r, skid_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid_r || out_tready) begin
        out_word_r <= {a_side_r.serr, fin_im, fin_re};
      end else begin
        skid_word_r <= {a_side_r.serr, fin_im, fin_re};
      end
    end else if (out_tready && skid_valid_r) begin
      out_word_r <= skid_word_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_word_r[35:0]};
  assign out_tuser  = out_word_r[36];

endmodule

FILE: rtl/tbg_div_cell.sv
// One restoring division step: shifts a dividend bit into the remainder.
`timescale 1ns / 1ps
module tbg_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  tbg_pkg::side_t side_i,
  input  tbg_pkg::div_t  d_i,
  output tbg_pkg::side_t side_o,
  output tbg_pkg::div_t  d_o
);

  tbg_pkg::side_t side_r;
  tbg_pkg::div_t  d_r;
  tbg_pkg::div_t  d_nxt;
  logic [tbg_pkg::M_W:0] trial;
  logic                  ge;

  always_comb begin
    trial = {d_i.rem, d_i.dq[tbg_pkg::DQ_W-1]};
    ge    = (trial >= {1'b0, d_i.m});
    d_nxt.m   = d_i.m;
    d_nxt.rem = ge ? tbg_pkg::M_W'(trial - {1'b0, d_i.m}) : trial[tbg_pkg::M_W-1:0];
    d_nxt.dq  = {d_i.dq[tbg_pkg::DQ_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign side_o = side_r;
  assign d_o    = d_r;

endmodule

FILE: rtl/tbg_tay_cell.sv
// One Taylor term for sine and cosine, in three pipeline stages.
`timescale 1ns / 1ps
module tbg_tay_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [2:0]     iter,
  input  tbg_pkg::side_t side_i,
  input  tbg_pkg::tay_t  t_i,
  output tbg_pkg::side_t side_o,
  output tbg_pkg::tay_t  t_o
);

  localparam logic [61:0] RND30 = 62'd1 << 29;

  logic [7:0]  ds, dc;
  logic [31:0] rs, rc;
  logic [61:0] ps, pc;
  logic [63:0] es_full, ec_full;
  logic [31:0] rems, remc, qs, qc;

  tbg_pkg::side_t s1_side_r, s2_side_r, s3_side_r;
  tbg_pkg::tay_t  s1_t_r, s2_t_r, s3_t_r;
  tbg_pkg::tay_t  s3_t_nxt;
  logic [31:0]    vs1_r, vc1_r, vs1_nxt, vc1_nxt;
  logic [31:0]    vs2_r, vc2_r, es2_r, ec2_r;

  assign ds = tbg_pkg::tay_ds(iter);
  assign dc = tbg_pkg::tay_dc(iter);
  assign rs = tbg_pkg::tay_rs(iter);
  assign rc = tbg_pkg::tay_rc(iter);

  // Stage 1: next power term, rounded back to Q30, plus half the divisor.
  assign ps      = 62'(t_i.ts) * 62'(t_i.x2);
  assign pc      = 62'(t_i.tc) * 62'(t_i.x2);
  assign vs1_nxt = 32'((ps + RND30) >> 30) + 32'(ds >> 1);
  assign vc1_nxt = 32'((pc + RND30) >> 30) + 32'(dc >> 1);

  // Stage 2: quotient estimate by reciprocal.
  assign es_full = 64'(vs1_r) * 64'(rs);
  assign ec_full = 64'(vc1_r) * 64'(rc);

  // Stage 3: correct the estimate and add or subtract the term.
  always_comb begin
    rems = vs2_r - es2_r * 32'(ds);
    remc = vc2_r - ec2_r * 32'(dc);
    qs   = (rems >= 32'(ds)) ? es2_r + 32'd1 : es2_r;
    qc   = (remc >= 32'(dc)) ? ec2_r + 32'd1 : ec2_r;
    s3_t_nxt    = s2_t_r;
    s3_t_nxt.ts = qs[tbg_pkg::T_W-1:0];
    s3_t_nxt.tc = qc[tbg_pkg::T_W-1:0];
    if (iter[0]) begin
      s3_t_nxt.ss = s2_t_r.ss - qs[tbg_pkg::T_W-1:0];
      s3_t_nxt.sc = s2_t_r.sc - qc[tbg_pkg::T_W-1:0];
    end else begin
      s3_t_nxt.ss = s2_t_r.ss + qs[tbg_pkg::T_W-1:0];
      s3_t_nxt.sc = s2_t_r.sc + qc[tbg_pkg::T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.valid <= 1'b0;
      s2_side_r.valid <= 1'b0;
      s3_side_r.valid <= 1'b0;
    end else if (en) begin
      s1_side_r <= side_i;
      s2_side_r <= s1_side_r;
      s3_side_r <= s2_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r <= t_i;
      vs1_r  <= vs1_nxt;
      vc1_r  <= vc1_nxt;
      s2_t_r <= s1_t_r;
      vs2_r  <= vs1_r;
      vc2_r  <= vc1_r;
      es2_r  <= es_full[63:32];
      ec2_r  <= ec_full[63:32];
      s3_t_r <= s3_t_nxt;
    end
  end

  assign side_o = s3_side_r;
  assign t_o    = s3_t_r;

endmodule

FILE: rtl/tbg_lane.sv
// One dimension: phase, exact reduction, octant angle, sine/cosine and 1D value.
`timescale 1ns / 1ps
module tbg_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  valid_i,
  input  logic                                  zero_i,
  input  logic                                  serr_i,
  input  logic [3:0]                            kind_i,
  input  logic signed [tbg_pkg::K_W-1:0]        k_i,
  input  logic [tbg_pkg::N_W-1:0]               n_i,
  input  logic [tbg_pkg::LEN_W-1:0]             len_i,
  output tbg_pkg::side_t                        side_o,
  output logic signed [tbg_pkg::LV_W-1:0]       re_o,
  output logic signed [tbg_pkg::LV_W-1:0]       im_o
);

  localparam logic signed [15:0] HALF = 16'sd1 <<< (tbg_pkg::FRAC_BITS - 1);
  localparam logic signed [15:0] ONE  = 16'sd1 <<< tbg_pkg::FRAC_BITS;

  // ---------------- front: operands, modulus and edge values ----------------
  tbg_pkg::side_t f0_side_r, f0_side_nxt;
  logic signed [17:0] f0_a_r, f0_a_nxt;
  logic [12:0]        f0_b_r, f0_b_nxt;
  logic [15:0]        f0_m_r, f0_m_nxt;

  logic signed [17:0] k18, a_2k, a_2k1, a_k1;
  logic [12:0]        n13, b_2n1, b_n1;
  logic [15:0]        l16;
  logic               n_zero, n_last;
  logic signed [15:0] hs;
  logic [3:0]         lg, hi_idx, lo_idx;
  logic               par, bw;

  always_comb begin
    k18    = 18'(k_i);
    a_2k   = {k_i[15], k_i, 1'b0};
    a_2k1  = {k_i[15], k_i, 1'b1};
    a_k1   = k18 + 18'sd1;
    n13    = {1'b0, n_i};
    b_2n1  = {n_i, 1'b1};
    b_n1   = n13 + 13'd1;
    l16    = 16'(len_i);
    n_zero = (n_i == '0);
    n_last = (n13 == len_i - 13'd1);
    hs     = k_i[0] ? -HALF : HALF;

    // Sequency-ordered Walsh sign: bit-reversed Gray code of the term.
    lg = 4'd0;
    for (int i = 0; i <= 12; i++) begin
      if (len_i[i]) lg = 4'(i);
    end
    par = 1'b0;
    for (int i = 0; i < 12; i++) begin
      hi_idx = lg - 4'(i) - 4'd1;
      lo_idx = lg - 4'(i);
      bw     = (i == 0) ? k_i[hi_idx] : (k_i[hi_idx] ^ k_i[lo_idx]);
      if ((4'(i) < lg) && n_i[i]) par = par ^ bw;
    end

    f0_side_nxt          = '0;
    f0_side_nxt.valid    = valid_i;
    f0_side_nxt.zero     = zero_i;
    f0_side_nxt.serr     = serr_i;
    f0_side_nxt.fn       = tbg_pkg::FN_COS;
    f0_a_nxt             = a_2k;
    f0_b_nxt             = n13;
    f0_m_nxt             = l16 << 1;

    case (kind_i)
      tbg_pkg::KIND_DFT:  f0_side_nxt.fn = tbg_pkg::FN_DFT;
      tbg_pkg::KIND_IDFT: f0_side_nxt.fn = tbg_pkg::FN_IDFT;
      tbg_pkg::KIND_HART: f0_side_nxt.fn = tbg_pkg::FN_HART;
      tbg_pkg::KIND_DCT1: begin
        f0_a_nxt = k18;
        f0_m_nxt = (l16 << 1) - 16'd2;
        if (n_zero) begin
          f0_side_nxt.spec     = 1'b1;
          f0_side_nxt.spec_val = HALF;
        end else if (len_i == 13'd1 || n_last) begin
          f0_side_nxt.spec     = 1'b1;
          f0_side_nxt.spec_val = hs;
        end
      end
      tbg_pkg::KIND_DCT2: begin
        f0_a_nxt = k18;
        f0_b_nxt = b_2n1;
        f0_m_nxt = l16 << 2;
      end
      tbg_pkg::KIND_DCT3: begin
        f0_a_nxt = a_2k1;
        f0_m_nxt = l16 << 2;
        if (n_zero) begin
          f0_side_nxt.spec     = 1'b1;
          f0_side_nxt.spec_val = HALF;
        end
      end
      tbg_pkg::KIND_DCT4, tbg_pkg::KIND_DST4: begin
        f0_a_nxt = a_2k1;
        f0_b_nxt = b_2n1;
        f0_m_nxt = l16 << 3;
        if (kind_i == tbg_pkg::KIND_DST4) f0_side_nxt.fn = tbg_pkg::FN_SIN;
      end
      tbg_pkg::KIND_DST1: begin
        f0_side_nxt.fn = tbg_pkg::FN_SIN;
        f0_a_nxt = a_k1;
        f0_b_nxt = b_n1;
        f0_m_nxt = (l16 << 1) + 16'd2;
      end
      tbg_pkg::KIND_DST2: begin
        f0_side_nxt.fn = tbg_pkg::FN_SIN;
        f0_a_nxt = a_k1;
        f0_b_nxt = b_2n1;
        f0_m_nxt = l16 << 2;
      end
      tbg_pkg::KIND_DST3: begin
        f0_side_nxt.fn = tbg_pkg::FN_SIN;
        f0_a_nxt = a_2k1;
        f0_b_nxt = b_n1;
        f0_m_nxt = l16 << 2;
        if (n_last) begin
          f0_side_nxt.spec     = 1'b1;
          f0_side_nxt.spec_val = hs;
        end
      end
      tbg_pkg::KIND_WHT: begin
        f0_side_nxt.spec     = 1'b1;
        f0_side_nxt.spec_val = par ? -ONE : ONE;
      end
      default: f0_side_nxt.spec = 1'b1;
    endcase
  end

  // ---------------- phase product and its magnitude ----------------
  tbg_pkg::side_t m0_side_r, m0_side_nxt;
  tbg_pkg::div_t  m0_d_r, m0_d_nxt;
  logic signed [31:0] pa, pb, prod;

  always_comb begin
    pa   = 32'(f0_a_r);
    pb   = signed'(32'(f0_b_r));
    prod = pa * pb;
    m0_side_nxt     = f0_side_r;
    m0_side_nxt.neg = prod[31];
    m0_d_nxt.rem    = '0;
    m0_d_nxt.m      = f0_m_r;
    m0_d_nxt.dq     = {1'b0, (prod[31] ? 31'(-prod) : prod[30:0])};
  end

  // ---------------- reduction modulo 2q ----------------
  tbg_pkg::side_t mod_s [0:tbg_pkg::MOD_CELLS];
  tbg_pkg::div_t  mod_d [0:tbg_pkg::MOD_CELLS];
  assign mod_s[0] = m0_side_r;
  assign mod_d[0] = m0_d_r;

  for (genvar g = 0; g < tbg_pkg::MOD_CELLS; g++) begin : g_mod
    tbg_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .side_i(mod_s[g]), .d_i(mod_d[g]),
      .side_o(mod_s[g+1]), .d_o(mod_d[g+1])
    );
  end

  // A negative phase folds back into [0, 2q).
  tbg_pkg::side_t o0_side_r;
  tbg_pkg::div_t  o0_d_r, o0_d_nxt;
  logic [15:0]    r0;

  always_comb begin
    r0 = mod_d[tbg_pkg::MOD_CELLS].rem;
    o0_d_nxt.m   = mod_d[tbg_pkg::MOD_CELLS].m;
    o0_d_nxt.rem = (mod_s[tbg_pkg::MOD_CELLS].neg && r0 != '0) ?
                   mod_d[tbg_pkg::MOD_CELLS].m - r0 : r0;
    o0_d_nxt.dq  = '0;
  end

  // ---------------- octant: three quotient bits of 8r / 2q ----------------
  tbg_pkg::side_t oct_s [0:tbg_pkg::OCT_CELLS];
  tbg_pkg::div_t  oct_d [0:tbg_pkg::OCT_CELLS];
  assign oct_s[0] = o0_side_r;
  assign oct_d[0] = o0_d_r;

  for (genvar g = 0; g < tbg_pkg::OCT_CELLS; g++) begin : g_oct
    tbg_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .side_i(oct_s[g]), .d_i(oct_d[g]),
      .side_o(oct_s[g+1]), .d_o(oct_d[g+1])
    );
  end

  // ---------------- angle numerator ----------------
  tbg_pkg::side_t n0_side_r, n0_side_nxt;
  logic [15:0]    n0_a_r, n0_a_nxt, n0_m_r;
  logic [45:0]    numer;
  tbg_pkg::side_t y0_side_r;
  tbg_pkg::div_t  y0_d_r, y0_d_nxt;

  always_comb begin
    n0_side_nxt     = oct_s[tbg_pkg::OCT_CELLS];
    n0_side_nxt.oct = oct_d[tbg_pkg::OCT_CELLS].dq[2:0];
    n0_a_nxt = oct_d[tbg_pkg::OCT_CELLS].dq[0] ?
               oct_d[tbg_pkg::OCT_CELLS].m - oct_d[tbg_pkg::OCT_CELLS].rem :
               oct_d[tbg_pkg::OCT_CELLS].rem;
    numer = 46'(n0_a_r) * 46'(tbg_pkg::Q30_PI4) + 46'(n0_m_r >> 1);
    y0_d_nxt.m   = n0_m_r;
    y0_d_nxt.rem = numer[45:30];
    y0_d_nxt.dq  = {numer[29:0], 2'b00};
  end

  // ---------------- angle in Q30: thirty quotient bits ----------------
  tbg_pkg::side_t y_s [0:tbg_pkg::Y_BITS];
  tbg_pkg::div_t  y_d [0:tbg_pkg::Y_BITS];
  assign y_s[0] = y0_side_r;
  assign y_d[0] = y0_d_r;

  for (genvar g = 0; g < tbg_pkg::Y_BITS; g++) begin : g_ang
    tbg_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .side_i(y_s[g]), .d_i(y_d[g]),
      .side_o(y_s[g+1]), .d_o(y_d[g+1])
    );
  end

  // ---------------- Taylor series ----------------
  tbg_pkg::side_t x0_side_r;
  tbg_pkg::tay_t  x0_t_r, x0_t_nxt;
  logic [29:0]    yv;
  logic [59:0]    yy;

  always_comb begin
    yv = y_d[tbg_pkg::Y_BITS].dq[29:0];
    yy = 60'(yv) * 60'(yv);
    x0_t_nxt.x2 = 31'((yy + (60'd1 << 29)) >> 30);
    x0_t_nxt.ts = 31'(yv);
    x0_t_nxt.ss = 31'(yv);
    x0_t_nxt.tc = tbg_pkg::Q30_ONE;
    x0_t_nxt.sc = tbg_pkg::Q30_ONE;
  end

  tbg_pkg::side_t tay_s [0:tbg_pkg::TAY_CELLS];
  tbg_pkg::tay_t  tay_d [0:tbg_pkg::TAY_CELLS];
  assign tay_s[0] = x0_side_r;
  assign tay_d[0] = x0_t_r;

  for (genvar g = 0; g < tbg_pkg::TAY_CELLS; g++) begin : g_tay
    tbg_tay_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .iter(3'(g + 1)),
      .side_i(tay_s[g]), .t_i(tay_d[g]),
      .side_o(tay_s[g+1]), .t_o(tay_d[g+1])
    );
  end

  // ---------------- rounding to FRAC_BITS and quadrant mapping ----------------
  tbg_pkg::side_t r0_side_r;
  logic [14:0]    s_r, c_r, s_nxt, c_nxt;
  logic [30:0]    ss_rnd, sc_rnd;

  always_comb begin
    ss_rnd = tay_d[tbg_pkg::TAY_CELLS].ss + (31'd1 << (29 - tbg_pkg::FRAC_BITS));
    sc_rnd = tay_d[tbg_pkg::TAY_CELLS].sc + (31'd1 << (29 - tbg_pkg::FRAC_BITS));
    s_nxt  = 15'(ss_rnd >> (30 - tbg_pkg::FRAC_BITS));
    c_nxt  = 15'(sc_rnd >> (30 - tbg_pkg::FRAC_BITS));
  end

  tbg_pkg::side_t out_side_r;
  logic signed [tbg_pkg::LV_W-1:0] re_r, im_r, re_nxt, im_nxt;
  logic signed [tbg_pkg::LV_W-1:0] s17, c17, sy, si, co;
  logic [1:0] quad;

  always_comb begin
    s17  = signed'(17'(s_r));
    c17  = signed'(17'(c_r));
    sy   = r0_side_r.oct[0] ? -s17 : s17;
    quad = r0_side_r.oct[2:1] + {1'b0, r0_side_r.oct[0]};
    case (quad)
      2'd0: begin si = sy;   co = c17;  end
      2'd1: begin si = c17;  co = -sy;  end
      2'd2: begin si = -sy;  co = -c17; end
      default: begin si = -c17; co = sy; end
    endcase
    im_nxt = '0;
    case (r0_side_r.fn)
      tbg_pkg::FN_COS:  re_nxt = co;
      tbg_pkg::FN_SIN:  re_nxt = si;
      tbg_pkg::FN_DFT: begin
        re_nxt = co;
        im_nxt = -si;
      end
      tbg_pkg::FN_IDFT: begin
        re_nxt = co;
        im_nxt = si;
      end
      tbg_pkg::FN_HART: re_nxt = co + si;
      default:          re_nxt = '0;
    endcase
    if (r0_side_r.spec) begin
      re_nxt = 17'(r0_side_r.spec_val);
      im_nxt = '0;
    end
  end

  // ---------------- registers outside the cells ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_side_r.valid  <= 1'b0;
      m0_side_r.valid  <= 1'b0;
      o0_side_r.valid  <= 1'b0;
      n0_side_r.valid  <= 1'b0;
      y0_side_r.valid  <= 1'b0;
      x0_side_r.valid  <= 1'b0;
      r0_side_r.valid  <= 1'b0;
      out_side_r.valid <= 1'b0;
    end else if (en) begin
      f0_side_r  <= f0_side_nxt;
      m0_side_r  <= m0_side_nxt;
      o0_side_r  <= mod_s[tbg_pkg::MOD_CELLS];
      n0_side_r  <= n0_side_nxt;
      y0_side_r  <= n0_side_r;
      x0_side_r  <= y_s[tbg_pkg::Y_BITS];
      r0_side_r  <= tay_s[tbg_pkg::TAY_CELLS];
      out_side_r <= r0_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_a_r <= f0_a_nxt;
      f0_b_r <= f0_b_nxt;
      f0_m_r <= f0_m_nxt;
      m0_d_r <= m0_d_nxt;
      o0_d_r <= o0_d_nxt;
      n0_a_r <= n0_a_nxt;
      n0_m_r <= oct_d[tbg_pkg::OCT_CELLS].m;
      y0_d_r <= y0_d_nxt;
      x0_t_r <= x0_t_nxt;
      s_r    <= s_nxt;
      c_r    <= c_nxt;
      re_r   <= re_nxt;
      im_r   <= im_nxt;
    end
  end

  assign side_o = out_side_r;
  assign re_o   = re_r;
  assign im_o   = im_r;

endmodule
